// ----- rtl/pp2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// pp2rgb_pkg
// Shared types, format codes and conversion constants for the packed pixel
// to RGB888 converter.
// ----------------------------------------------------------------------------
package pp2rgb_pkg;

  typedef enum logic [1:0] {
    FMT_YUYV   = 2'd0,
    FMT_RGB565 = 2'd1,
    FMT_UYVY   = 2'd2
  } fmt_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  // width of the fixed-point channel sum (Y*256 plus weighted chroma)
  localparam int SumW = 19;

  localparam logic signed [9:0] CoefRv = 10'sd359;
  localparam logic signed [9:0] CoefGu = 10'sd88;
  localparam logic signed [9:0] CoefGv = 10'sd183;
  localparam logic signed [9:0] CoefBu = 10'sd454;
  localparam logic [8:0]        ChromaOffset = 9'd128;

  localparam logic [7:0]  MaskR = 8'd248;
  localparam logic [15:0] MaskG = 16'd2016;
  localparam logic [7:0]  MaskB = 8'd31;

  // floor(x / 256), clamped to 0..255
  function automatic logic [7:0] scale_clamp(input logic signed [SumW-1:0] x);
    logic [7:0] res;
    if (x[SumW-1]) begin
      res = 8'd0;
    end else if (|x[SumW-2:16]) begin
      res = 8'd255;
    end else begin
      res = x[15:8];
    end
    return res;
  endfunction

endpackage

// ----- rtl/pp2rgb_lane.sv -----
// ----------------------------------------------------------------------------
// pp2rgb_lane
// One pixel lane: weighted chroma products and RGB565 unpack in the first stage,
// channel sums, scaling and clamping (or RGB565 pass-through) in the second.
// ----------------------------------------------------------------------------
module pp2rgb_lane
  import pp2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  fmt_t       fmt,
  input  logic [7:0] y,
  input  logic [7:0] u,
  input  logic [7:0] v,
  input  logic [7:0] lo,
  input  logic [7:0] hi,
  output logic       out_valid,
  output pixel_t     pix
);

  logic signed [8:0] u_c;
  logic signed [8:0] v_c;
  logic [15:0]       word565;

  logic                   s1_valid;
  fmt_t                   s1_fmt;
  logic [7:0]             s1_y;
  logic signed [SumW-1:0] s1_pr;
  logic signed [SumW-1:0] s1_pgu;
  logic signed [SumW-1:0] s1_pgv;
  logic signed [SumW-1:0] s1_pb;
  pixel_t                 s1_rgb;

  logic signed [SumW-1:0] y_ext;
  logic signed [SumW-1:0] sum_r;
  logic signed [SumW-1:0] sum_g;
  logic signed [SumW-1:0] sum_b;
  pixel_t                 pix_next;

  assign u_c     = $signed({1'b0, u} - ChromaOffset);
  assign v_c     = $signed({1'b0, v} - ChromaOffset);
  assign word565 = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_fmt   <= fmt;
    s1_y     <= y;
    s1_pr    <= SumW'(v_c * CoefRv);
    s1_pgu   <= SumW'(u_c * CoefGu);
    s1_pgv   <= SumW'(v_c * CoefGv);
    s1_pb    <= SumW'(u_c * CoefBu);
    s1_rgb.r <= hi & MaskR;
    s1_rgb.g <= 8'((word565 & MaskG) >> 3);
    s1_rgb.b <= {lo[4:0] & MaskB[4:0], 3'b000};
  end

  assign y_ext = $signed({3'b000, s1_y, 8'h00});
  assign sum_r = y_ext + s1_pr;
  assign sum_g = y_ext - s1_pgu - s1_pgv;
  assign sum_b = y_ext + s1_pb;

  always_comb begin
    unique case (s1_fmt)
      FMT_YUYV, FMT_UYVY: begin
        pix_next.r = scale_clamp(sum_r);
        pix_next.g = scale_clamp(sum_g);
        pix_next.b = scale_clamp(sum_b);
      end
      FMT_RGB565: pix_next = s1_rgb;
      default:    pix_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_valid;
    end
    pix <= pix_next;
  end

  a_valid_follows: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> out_valid)
    else $error("lane valid lost between stages");

  a_rgb565_low_bits: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_fmt == FMT_RGB565) |=> (pix.r[2:0] == 3'b000 && pix.b[2:0] == 3'b000
                                           && pix.g[1:0] == 2'b00))
    else $error("RGB565 unpack left low bits set");

endmodule

// ----- rtl/pp2rgb_merge.sv -----
// ----------------------------------------------------------------------------
// pp2rgb_merge
// Joins the two lane pixels into one result item and registers it with the
// done strobe.
// ----------------------------------------------------------------------------
module pp2rgb_merge
  import pp2rgb_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   valid_first,
  input  logic   valid_second,
  input  pixel_t pix_first,
  input  pixel_t pix_second,
  output logic   done,
  output pixel_t res_first,
  output pixel_t res_second
);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_first & valid_second;
    end
    res_first  <= pix_first;
    res_second <= pix_second;
  end

endmodule

// ----- rtl/packed_pixel_to_rgb888_top.sv -----
// ----------------------------------------------------------------------------
// packed_pixel_to_rgb888_top
// Converts a 32-bit word holding two pixels (YUYV, UYVY or RGB565) into two
// RGB888 pixels using two conversion lanes and a merging output register.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy is always low, the lanes are pipelined.
// Depth is set by the lane multiply stage, the sum/clamp stage and the output
// register. Results cannot be stalled.
// Reset (rst, synchronous): clears pipeline valids and sets format to YUYV.
module packed_pixel_to_rgb888_top
  import pp2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_data,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] byte_0,
  input  logic [7:0] byte_1,
  input  logic [7:0] byte_2,
  input  logic [7:0] byte_3,
  output logic       done,
  output logic [7:0] red_first,
  output logic [7:0] green_first,
  output logic [7:0] blue_first,
  output logic [7:0] red_second,
  output logic [7:0] green_second,
  output logic [7:0] blue_second
);

  fmt_t       fmt_sel;
  logic       accept;
  logic [7:0] y0, y1, u_s, v_s;
  logic       lane0_valid, lane1_valid;
  pixel_t     lane0_pix, lane1_pix;
  pixel_t     res_first, res_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt_sel <= FMT_YUYV;
    end else if (cfg_we) begin
      fmt_sel <= fmt_t'(cfg_data);
    end
  end

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // UYVY swaps luma and chroma byte positions
  always_comb begin
    if (fmt_sel == FMT_UYVY) begin
      y0  = byte_1;
      y1  = byte_3;
      u_s = byte_0;
      v_s = byte_2;
    end else begin
      y0  = byte_0;
      y1  = byte_2;
      u_s = byte_1;
      v_s = byte_3;
    end
  end

  pp2rgb_lane u_lane0 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .fmt       (fmt_sel),
    .y         (y0),
    .u         (u_s),
    .v         (v_s),
    .lo        (byte_0),
    .hi        (byte_1),
    .out_valid (lane0_valid),
    .pix       (lane0_pix)
  );

  pp2rgb_lane u_lane1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .fmt       (fmt_sel),
    .y         (y1),
    .u         (u_s),
    .v         (v_s),
    .lo        (byte_2),
    .hi        (byte_3),
    .out_valid (lane1_valid),
    .pix       (lane1_pix)
  );

  pp2rgb_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .valid_first  (lane0_valid),
    .valid_second (lane1_valid),
    .pix_first    (lane0_pix),
    .pix_second   (lane1_pix),
    .done         (done),
    .res_first    (res_first),
    .res_second   (res_second)
  );

  assign red_first    = res_first.r;
  assign green_first  = res_first.g;
  assign blue_first   = res_first.b;
  assign red_second   = res_second.r;
  assign green_second = res_second.g;
  assign blue_second  = res_second.b;

  a_item_completes: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 done)
    else $error("accepted item produced no result");

  a_no_spurious_done: assert property (@(posedge clk)
    done |-> $past(accept, 3))
    else $error("result without an accepted item");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    lane0_valid == lane1_valid)
    else $error("pixel lanes out of step");

endmodule
